/* design/lzwe_pkg.sv */
// Shared constants, types and hash function for the LZW encoder.
package lzwe_pkg;

  localparam int DICT_ENTRIES = 4096;
  localparam int ROOT_CODES   = 256;
  localparam int CODE_AW      = $clog2(DICT_ENTRIES);
  localparam int NFC_W        = CODE_AW + 1;
  localparam int OUT_W        = 12;
  localparam int KEY_W        = CODE_AW + 8;
  localparam int HT_DEPTH     = 2 * DICT_ENTRIES;
  localparam int HT_AW        = $clog2(HT_DEPTH);
  localparam int EPOCH_W      = 4;
  localparam int IQ_DEPTH     = 2;
  localparam int IQ_AW        = $clog2(IQ_DEPTH);
  localparam int IQ_CW        = $clog2(IQ_DEPTH + 1);
  localparam int OQ_DEPTH     = 4;
  localparam int OQ_AW        = $clog2(OQ_DEPTH);
  localparam int OQ_CW        = $clog2(OQ_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0] out_code;
    logic             final_code;
  } res_t;

  // Hash table slot: epoch tag, (prefix, byte) key, assigned code
  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [KEY_W-1:0]   key;
    logic [CODE_AW-1:0] code;
  } slot_t;

  // Home slot of a (prefix, byte) pair
  function automatic logic [HT_AW-1:0] ht_hash(input logic [CODE_AW-1:0] pfx,
                                               input logic [7:0] b);
    ht_hash = HT_AW'(pfx) ^ (HT_AW'(b) << (HT_AW - 8));
  endfunction

endpackage

/* design/lzwe_front.sv */
// Input queue: accepts byte transactions and holds them for the dictionary engine.
module lzwe_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  lzwe_pkg::item_t in_item,
  output logic          item_avail,
  output lzwe_pkg::item_t item,
  input  logic          item_pop
);
  import lzwe_pkg::*;

  item_t            q [IQ_DEPTH];
  logic [IQ_AW-1:0] wr_ptr;
  logic [IQ_AW-1:0] rd_ptr;
  logic [IQ_CW-1:0] cnt;
  logic             do_push;
  logic             do_pop;

  assign full       = (cnt == IQ_CW'(IQ_DEPTH));
  assign item_avail = (cnt != '0);
  assign item       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_avail;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      cnt <= cnt + IQ_CW'(do_push) - IQ_CW'(do_pop);
    end
  end

endmodule

/* design/lzwe_back.sv */
// Dictionary engine: hash-table lookup with linear probing, insert and code emission.
module lzwe_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    item_avail,
  input  lzwe_pkg::item_t         item,
  output logic                    item_pop,
  input  logic [lzwe_pkg::OQ_CW-1:0] oq_cnt,
  output logic                    res_push,
  output lzwe_pkg::res_t          res
);
  import lzwe_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CMP, S_LAST} state_t;

  state_t             state;
  logic [EPOCH_W-1:0] epoch;
  logic [NFC_W-1:0]   nfc;
  logic [CODE_AW-1:0] prefix;
  logic               pvalid;
  item_t              cur;
  logic [HT_AW-1:0]   probe;
  logic [HT_AW-1:0]   clr;

  slot_t              mem [HT_DEPTH];
  slot_t              rd_data;
  logic               rd_en;
  logic [HT_AW-1:0]   rd_addr;
  logic               wr_en;
  logic [HT_AW-1:0]   wr_addr;
  slot_t              wr_data;

  logic               take;
  logic               slot_used;
  logic               slot_match;
  logic               room;
  logic [KEY_W-1:0]   cur_key;

  // two result slots must be free, counting a push still in flight
  assign room = ({1'b0, oq_cnt} + (OQ_CW + 1)'(res_push)) <= (OQ_CW + 1)'(OQ_DEPTH - 2);
  assign take = (state == S_IDLE) && item_avail && room;
  assign item_pop = take;

  assign cur_key    = {prefix, cur.data_byte};
  assign slot_used  = (rd_data.tag == epoch);
  assign slot_match = (rd_data.key == cur_key);

  // table port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = probe;
    wr_en   = 1'b0;
    wr_addr = probe;
    wr_data = '{tag: epoch, key: cur_key, code: nfc[CODE_AW-1:0]};
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr;
        wr_data = '0;
      end
      S_IDLE: begin
        if (take && pvalid) begin
          rd_en   = 1'b1;
          rd_addr = ht_hash(prefix, item.data_byte);
        end
      end
      S_CMP: begin
        if (slot_used && !slot_match) begin
          rd_en   = 1'b1;
          rd_addr = probe + 1'b1;
        end else if (!slot_used && (nfc < NFC_W'(DICT_ENTRIES))) begin
          wr_en = 1'b1;
        end
      end
      S_LAST: ;
      default: ;
    endcase
  end

  // hash table memory
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr      <= '0;
      epoch    <= '0;
      nfc      <= NFC_W'(ROOT_CODES);
      prefix   <= '0;
      pvalid   <= 1'b0;
      res_push <= 1'b0;
    end else begin
      res_push <= 1'b0;
      if (rd_en) probe <= rd_addr;
      unique case (state)
        // sweep every slot to a tag no stream uses
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == HT_AW'(HT_DEPTH - 1)) begin
            epoch <= EPOCH_W'(1);
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (take) begin
            cur <= item;
            if (pvalid) begin
              state <= S_CMP;
            end else if (item.end_of_data) begin
              // single-byte stream
              res_push <= 1'b1;
              res      <= '{out_code: OUT_W'(item.data_byte), final_code: 1'b1};
              nfc      <= NFC_W'(ROOT_CODES);
              prefix   <= '0;
              if (epoch == '1) begin
                clr   <= '0;
                state <= S_CLEAR;
              end else begin
                epoch <= epoch + 1'b1;
              end
            end else begin
              prefix <= CODE_AW'(item.data_byte);
              pvalid <= 1'b1;
            end
          end
        end
        S_CMP: begin
          if (slot_used && slot_match) begin
            // string extends silently
            if (cur.end_of_data) begin
              res_push <= 1'b1;
              res      <= '{out_code: OUT_W'(rd_data.code), final_code: 1'b1};
              pvalid   <= 1'b0;
              prefix   <= '0;
              nfc      <= NFC_W'(ROOT_CODES);
              if (epoch == '1) begin
                clr   <= '0;
                state <= S_CLEAR;
              end else begin
                epoch <= epoch + 1'b1;
                state <= S_IDLE;
              end
            end else begin
              prefix <= rd_data.code;
              state  <= S_IDLE;
            end
          end else if (!slot_used) begin
            // miss: emit prefix, add entry if the dictionary has room, restart from the byte
            res_push <= 1'b1;
            res      <= '{out_code: OUT_W'(prefix), final_code: 1'b0};
            if (nfc < NFC_W'(DICT_ENTRIES)) nfc <= nfc + 1'b1;
            prefix   <= CODE_AW'(cur.data_byte);
            state    <= cur.end_of_data ? S_LAST : S_IDLE;
          end
        end
        // final code after a miss on the last byte
        S_LAST: begin
          res_push <= 1'b1;
          res      <= '{out_code: OUT_W'(prefix), final_code: 1'b1};
          pvalid   <= 1'b0;
          prefix   <= '0;
          nfc      <= NFC_W'(ROOT_CODES);
          if (epoch == '1) begin
            clr   <= '0;
            state <= S_CLEAR;
          end else begin
            epoch <= epoch + 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

endmodule

/* design/lzwe_out.sv */
// Result queue: holds emitted codes until the receiver pops them.
module lzwe_out (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       res_push,
  input  lzwe_pkg::res_t             res,
  output logic [lzwe_pkg::OQ_CW-1:0] oq_cnt,
  input  logic                       pop,
  output logic                       empty,
  output lzwe_pkg::res_t             head
);
  import lzwe_pkg::*;

  res_t             q [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr;
  logic [OQ_AW-1:0] rd_ptr;
  logic             do_pop;

  assign empty  = (oq_cnt == '0);
  assign head   = q[rd_ptr];
  assign do_pop = pop && !empty;

  // storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      q[wr_ptr] <= res;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      oq_cnt <= '0;
    end else begin
      if (res_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)   rd_ptr <= rd_ptr + 1'b1;
      oq_cnt <= oq_cnt + OQ_CW'(res_push) - OQ_CW'(do_pop);
    end
  end

endmodule

/* design/lzw_encoder.sv */
// Top level of the streaming LZW encoder.
//
// Input channel: push/full. Each transaction carries one data_byte and
// end_of_data, which marks the last byte of a stream. Result channel:
// empty/pop. Each transaction carries one out_code and final_code, which
// marks the last code of a stream.
// A two-entry input queue feeds the dictionary engine; a four-entry result
// queue decouples it from the receiver. The dictionary is a hash table of
// 2*DICT_ENTRIES slots probed linearly, one slot read per cycle.
// Item handling: an item that starts a stream is taken in S_IDLE alone;
// any other item then passes through S_CMP, which probes successive slots
// until a hit or an empty slot; a miss on the last byte adds S_LAST. A new
// byte is taken only in S_IDLE. Codes leave via the res register and the
// result queue. Reset: a clearing pass writes all HT_DEPTH (8192) slots and
// tags every slot stale; bytes queue up meanwhile, up to two. The same pass
// runs after every 15th stream, when the 4-bit stream tag wraps.
// A stalled receiver fills the result queue; the engine then stops taking
// bytes and the input queue raises full. Nothing is dropped.
module lzw_encoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        end_of_data,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] out_code,
  output logic        final_code
);
  import lzwe_pkg::*;

  item_t            in_item;
  item_t            item;
  logic             item_avail;
  logic             item_pop;
  logic [OQ_CW-1:0] oq_cnt;
  logic             res_push;
  res_t             res;
  res_t             head;

  assign in_item    = '{data_byte: data_byte, end_of_data: end_of_data};
  assign out_code   = head.out_code;
  assign final_code = head.final_code;

  lzwe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .in_item    (in_item),
    .item_avail (item_avail),
    .item       (item),
    .item_pop   (item_pop)
  );

  lzwe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_avail (item_avail),
    .item       (item),
    .item_pop   (item_pop),
    .oq_cnt     (oq_cnt),
    .res_push   (res_push),
    .res        (res)
  );

  lzwe_out u_out (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .oq_cnt   (oq_cnt),
    .pop      (pop),
    .empty    (empty),
    .head     (head)
  );

  // engine never pushes into a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (oq_cnt != OQ_CW'(OQ_DEPTH)))
    else $error("result queue overflow");

  // engine only takes a byte the input queue holds
  a_pop_avail: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_avail)
    else $error("byte taken from empty input queue");

  // result queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

endmodule

/* test/lzw_encoder_test.sv */
// Self-checking testbench for the streaming LZW encoder.
`timescale 1ns / 1ps

module lzw_encoder_test;
  import lzwe_pkg::*;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        end_of_data;
  logic        empty;
  logic        pop;
  logic [11:0] out_code;
  logic        final_code;

  lzw_encoder uut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .data_byte(data_byte), .end_of_data(end_of_data),
    .empty(empty), .pop(pop), .out_code(out_code), .final_code(final_code)
  );

  // Predictor state: dictionary of (prefix, byte) keys and current prefix
  logic [19:0] dict_key [DICT_ENTRIES];
  int unsigned dict_next;
  logic [11:0] cur_prefix;
  bit          have_prefix;

  // Expected codes in arrival order
  res_t code_queue[$];

  // Codes predicted for the most recent byte
  int   n_pred;
  res_t last_pred;

  int errors;
  int items_sent;
  int codes_seen;
  int streams_sent;
  int full_codes;
  bit recv_hold;
  bit sending_done;

  // Directed rows: byte, last flag, expected codes typed in where obvious
  typedef struct {
    logic [7:0] b;
    logic       last;
    int         n_exp;
    logic [11:0] c0;
    logic        f0;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("lzw_encoder_test failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d, want %0d (code %0d)", what, got, want, codes_seen);
  endtask

  function automatic bit dict_find(input logic [11:0] pfx, input logic [7:0] b,
                                   output logic [11:0] hit);
    logic [19:0] key;
    key = {pfx, b};
    hit = '0;
    for (int c = ROOT_CODES; c < dict_next; c++) begin
      if (dict_key[c] == key) begin
        hit = c[11:0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Compute expected codes for one accepted byte
  task automatic predict_codes(input logic [7:0] b, input logic last);
    logic [11:0] hit;
    n_pred = 0;
    if (!have_prefix) begin
      cur_prefix = {4'd0, b};
      have_prefix = 1'b1;
    end else if (dict_find(cur_prefix, b, hit)) begin
      cur_prefix = hit;
    end else begin
      last_pred = '{out_code: cur_prefix, final_code: 1'b0};
      code_queue.push_back(last_pred);
      n_pred++;
      if (dict_next < DICT_ENTRIES) begin
        dict_key[dict_next] = {cur_prefix, b};
        dict_next++;
      end else begin
        full_codes++;
      end
      cur_prefix = {4'd0, b};
    end
    if (last) begin
      last_pred = '{out_code: cur_prefix, final_code: 1'b1};
      code_queue.push_back(last_pred);
      n_pred++;
      have_prefix = 1'b0;
      cur_prefix = '0;
      dict_next = ROOT_CODES;
      streams_sent++;
    end
  endtask

  // Drive one transaction after a random gap; starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    data_byte <= b;
    end_of_data <= last;
    do @(posedge clk); while (full);
    predict_codes(b, last);
    items_sent++;
    @(negedge clk);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    int wait_n;
    res_t want;
    pop = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (recv_hold) begin
        pop <= 1'b0;
        for (int i = 0; i < 400; i++) @(negedge clk);
        recv_hold = 1'b0;
      end
      wait_n = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 6);
      if (wait_n > 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (code_queue.size() == 0) begin
        report_mismatch("unexpected code", out_code, -1);
      end else begin
        want = code_queue.pop_front();
        if (out_code !== want.out_code)
          report_mismatch("out_code", out_code, want.out_code);
        if (final_code !== want.final_code)
          report_mismatch("final_code", final_code, want.final_code);
      end
      codes_seen++;
      @(negedge clk);
    end
  end

  // Directed rows followed by random streams
  initial begin
    row_t rows[$];
    int len;
    int kind;
    int budget;
    logic [7:0] alpha;
    errors = 0;
    items_sent = 0;
    codes_seen = 0;
    streams_sent = 0;
    full_codes = 0;
    n_pred = 0;
    last_pred = '0;
    recv_hold = 1'b0;
    sending_done = 1'b0;
    dict_next = ROOT_CODES;
    have_prefix = 1'b0;
    cur_prefix = '0;
    rst = 1'b1;
    push = 1'b0;
    data_byte = '0;
    end_of_data = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Single-byte streams, including the extremes, then repeats that grow prefixes
    rows.push_back('{8'h00, 1'b1, 1, 12'h000, 1'b1});
    rows.push_back('{8'hFF, 1'b1, 1, 12'h0FF, 1'b1});
    rows.push_back('{8'hA5, 1'b1, 1, 12'h0A5, 1'b1});
    rows.push_back('{8'h5A, 1'b1, 1, 12'h05A, 1'b1});
    for (int i = 0; i < 10; i++) rows.push_back('{8'h41, 1'b0, -1, 12'h0, 1'b0});
    rows.push_back('{8'h41, 1'b1, -1, 12'h0, 1'b0});
    rows.push_back('{8'h00, 1'b0, -1, 12'h0, 1'b0});
    rows.push_back('{8'hFF, 1'b0, -1, 12'h0, 1'b0});
    rows.push_back('{8'h00, 1'b0, -1, 12'h0, 1'b0});
    rows.push_back('{8'hFF, 1'b0, -1, 12'h0, 1'b0});
    rows.push_back('{8'h00, 1'b0, -1, 12'h0, 1'b0});
    rows.push_back('{8'hFF, 1'b1, -1, 12'h0, 1'b0});
    foreach (rows[i]) begin
      send_byte(rows[i].b, rows[i].last);
      if (rows[i].n_exp == 1) begin
        // Typed-in value must agree with the predictor's own answer
        if (n_pred != 1 || last_pred.out_code !== rows[i].c0 ||
            last_pred.final_code !== rows[i].f0)
          report_mismatch("directed row", i, rows[i].c0);
      end
    end

    // Long receiver hold-off while bytes keep coming
    recv_hold = 1'b1;
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'h7E, 1'b1);

    // Random streams: mostly small alphabets for deep matching
    budget = 850;
    while (budget > 0) begin
      len = $urandom_range(1, 60);
      kind = $urandom_range(0, 3);
      alpha = 8'($urandom_range(0, 255));
      for (int i = 0; i < len; i++) begin
        logic [7:0] b;
        case (kind)
          0: b = 8'($urandom_range(0, 255));
          1: b = alpha ^ 8'($urandom_range(0, 1));
          default: b = alpha + 8'($urandom_range(0, 3));
        endcase
        send_byte(b, (i == len - 1));
        budget--;
      end
    end
    push <= 1'b0;
    sending_done = 1'b1;
  end

  // Drain, settle, report
  initial begin
    int guard;
    @(negedge clk);
    wait (sending_done);
    guard = 0;
    while (code_queue.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (50) @(negedge clk);
    if (code_queue.size() != 0) begin
      errors++;
      $display("%0d expected codes never arrived", code_queue.size());
    end
    $display("Sent %0d bytes in %0d streams, checked %0d codes", items_sent, streams_sent,
             codes_seen);
    $display("Misses with a full dictionary: %0d; errors: %0d", full_codes, errors);
    if (errors == 0) begin
      $display("lzw_encoder_test passed");
    end else begin
      $display("lzw_encoder_test failed");
    end
    $finish;
  end

endmodule

/* lzw_encoder.f */
design/lzwe_pkg.sv
design/lzwe_front.sv
design/lzwe_back.sv
design/lzwe_out.sv
design/lzw_encoder.sv
test/lzw_encoder_test.sv
